// File: rtl/hcc_pkg.sv
// ----------------------------------------------------------------------------
// hcc_pkg
// Shared widths and limits of the Huffman code cost unit and its checker.
// ----------------------------------------------------------------------------
package hcc_pkg;

    // Fixed field widths of the item channels
    localparam int WEIGHT_W = 16;
    localparam int COST_W   = 28;
    localparam int COUNT_W  = 7;

    // Saturation limits of the result fields
    localparam logic [COST_W-1:0]  COST_MAX  = 28'hFFFFFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

endpackage

// File: rtl/huffman_code_cost_unit.sv
// ----------------------------------------------------------------------------
// huffman_code_cost_unit
// Min-heap in a two-read, one-write synchronous RAM; computes the weighted
// path length of an optimal prefix code for one set of symbol weights.
// ----------------------------------------------------------------------------
// Insert: an item is taken in S_IDLE; sift-up then moves parent entries down in
//   S_UP_CMP until the new entry settles, and writes it there.
// Item marked last: (n-1) merge rounds (pop with sift-down, replace root
//   with the sum, sift-down), then S_MRG_RD sees a single entry left and
//   S_EMIT loads the result register, held while the output register is
//   full. One item is worked on at a time.
// Reset: asynchronous, clears the control state and counters; heap RAM
//   contents stay undefined until written, no clearing pass.
module huffman_code_cost_unit
    import hcc_pkg::*;
#(
    parameter int MAX_SYMBOLS = 64,
    parameter int WEIGHT_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [WEIGHT_W-1:0] weight,
    input  logic                last,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [COST_W-1:0]   total_cost,
    output logic [COUNT_W-1:0]  symbol_count,
    output logic                overflow
);

    localparam int IDX_W   = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int CNT_W   = $clog2(MAX_SYMBOLS + 1);
    localparam int EFF_W   = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;
    localparam int ENTRY_W = EFF_W + IDX_W;
    localparam int POS_W   = IDX_W + 2;
    localparam int SAT_W   = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_UP_CMP  = 9'b000000010,
        S_WR_FIN  = 9'b000000100,
        S_MRG_RD  = 9'b000001000,
        S_MRG_POP = 9'b000010000,
        S_MRG_TOP = 9'b000100000,
        S_MRG_REP = 9'b001000000,
        S_DN_CMP  = 9'b010000000,
        S_EMIT    = 9'b100000000
    } state_t;

    typedef enum logic [1:0] {
        RET_IN  = 2'b00,
        RET_POP = 2'b01,
        RET_REP = 2'b10
    } ret_t;

    // Heap RAM
    logic [ENTRY_W-1:0] heap_mem [MAX_SYMBOLS];
    logic [ENTRY_W-1:0] rd0_data_reg;
    logic [ENTRY_W-1:0] rd1_data_reg;
    logic [IDX_W-1:0]   rd0_addr;
    logic [IDX_W-1:0]   rd1_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    // Control and working registers
    state_t             state_reg, state_next;
    ret_t               ret_reg, ret_next;
    logic               last_reg, last_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   nsym_reg, nsym_next;
    logic [COST_W-1:0]  acc_reg, acc_next;
    logic               ovf_reg, ovf_next;
    logic [IDX_W-1:0]   hole_reg, hole_next;
    logic [ENTRY_W-1:0] val_reg, val_next;
    logic [ENTRY_W-1:0] a_reg, a_next;

    // Result register
    logic               out_valid_reg, out_valid_next;
    logic [COST_W-1:0]  total_cost_reg;
    logic [COUNT_W-1:0] symbol_count_reg;
    logic               overflow_reg;
    logic               out_load;

    // Datapath signals
    logic [ENTRY_W-1:0] w_entry;
    logic [IDX_W-1:0]   in_parent;
    logic [IDX_W-1:0]   up_parent;
    logic [IDX_W-1:0]   up_gparent;
    logic [POS_W-1:0]   cnt_pos;
    logic [POS_W-1:0]   lc, rc, nlc, nrc;
    logic               pick_right;
    logic [ENTRY_W-1:0] child_val;
    logic [IDX_W-1:0]   child_idx;
    logic               next_has_child;
    logic [ENTRY_W-1:0] pair_sum;
    logic [COST_W:0]    acc_sum;
    logic [COST_W-1:0]  acc_sat;
    logic [SAT_W-1:0]   sym_wide;
    logic [COUNT_W-1:0] sym_sat;
    state_t             done_state;

    // Store write, registered reads
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            heap_mem[wr_addr] <= wr_data;
        end
        rd0_data_reg <= heap_mem[rd0_addr];
        rd1_data_reg <= heap_mem[rd1_addr];
    end

    // Mask the incoming weight to the configured width
    assign w_entry = ENTRY_W'(weight[EFF_W-1:0]);

    // Parent indexes for sift-up
    assign in_parent  = IDX_W'((count_reg - CNT_W'(1)) >> 1);
    assign up_parent  = (hole_reg - IDX_W'(1)) >> 1;
    assign up_gparent = (up_parent - IDX_W'(1)) >> 1;

    // Child selection for sift-down
    assign cnt_pos        = POS_W'(count_reg);
    assign lc             = POS_W'({hole_reg, 1'b1});
    assign rc             = lc + POS_W'(1);
    assign pick_right     = (rc < cnt_pos) && (rd1_data_reg < rd0_data_reg);
    assign child_val      = pick_right ? rd1_data_reg : rd0_data_reg;
    assign child_idx      = pick_right ? rc[IDX_W-1:0] : lc[IDX_W-1:0];
    assign nlc            = POS_W'({child_idx, 1'b1});
    assign nrc            = nlc + POS_W'(1);
    assign next_has_child = nlc < cnt_pos;

    // Merge sum and saturating cost
    assign pair_sum = a_reg + rd0_data_reg;
    assign acc_sum  = {1'b0, acc_reg} + (COST_W + 1)'(pair_sum);
    assign acc_sat  = (acc_sum > {1'b0, COST_MAX}) ? COST_MAX : acc_sum[COST_W-1:0];

    // Saturate the symbol count
    assign sym_wide = SAT_W'(nsym_reg);
    assign sym_sat  = (sym_wide > SAT_W'(COUNT_MAX)) ? COUNT_MAX : sym_wide[COUNT_W-1:0];

    // Where a finished sift returns to
    always_comb
    begin
        unique case (ret_reg)
            RET_IN:  done_state = last_reg ? S_MRG_RD : S_IDLE;
            RET_POP: done_state = S_MRG_TOP;
            RET_REP: done_state = S_MRG_RD;
            default: done_state = S_IDLE;
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        last_next      = last_reg;
        count_next     = count_reg;
        nsym_next      = nsym_reg;
        acc_next       = acc_reg;
        ovf_next       = ovf_reg;
        hole_next      = hole_reg;
        val_next       = val_reg;
        a_next         = a_reg;
        wr_en          = 1'b0;
        wr_addr        = hole_reg;
        wr_data        = val_reg;
        rd0_addr       = '0;
        rd1_addr       = '0;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            S_IDLE:
            begin
                rd0_addr = in_parent;
                if (in_valid)
                begin
                    last_next = last;
                    ret_next  = RET_IN;
                    if (count_reg == CNT_W'(MAX_SYMBOLS))
                    begin
                        // Heap full: drop the weight
                        ovf_next   = 1'b1;
                        state_next = last ? S_MRG_RD : S_IDLE;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                        nsym_next  = nsym_reg + CNT_W'(1);
                        val_next   = w_entry;
                        hole_next  = IDX_W'(count_reg);
                        if (count_reg == '0)
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = '0;
                            wr_data    = w_entry;
                            state_next = last ? S_MRG_RD : S_IDLE;
                        end
                        else
                        begin
                            state_next = S_UP_CMP;
                        end
                    end
                end
            end

            S_UP_CMP:
            begin
                // Move the parent down or settle the new entry
                rd0_addr = up_gparent;
                wr_en    = 1'b1;
                if (val_reg < rd0_data_reg)
                begin
                    wr_data    = rd0_data_reg;
                    hole_next  = up_parent;
                    state_next = (up_parent == '0) ? S_WR_FIN : S_UP_CMP;
                end
                else
                begin
                    state_next = done_state;
                end
            end

            S_WR_FIN:
            begin
                wr_en      = 1'b1;
                state_next = done_state;
            end

            S_MRG_RD:
            begin
                // Fetch root and last entry
                rd0_addr   = '0;
                rd1_addr   = IDX_W'(count_reg - CNT_W'(1));
                state_next = (count_reg > CNT_W'(1)) ? S_MRG_POP : S_EMIT;
            end

            S_MRG_POP:
            begin
                // Take the root, sift the last entry down from the top
                a_next     = rd0_data_reg;
                val_next   = rd1_data_reg;
                hole_next  = '0;
                count_next = count_reg - CNT_W'(1);
                ret_next   = RET_POP;
                rd0_addr   = IDX_W'(1);
                rd1_addr   = IDX_W'(2);
                if (count_reg > CNT_W'(2))
                begin
                    state_next = S_DN_CMP;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                    wr_data    = rd1_data_reg;
                    state_next = S_MRG_TOP;
                end
            end

            S_MRG_TOP:
            begin
                rd0_addr   = '0;
                state_next = S_MRG_REP;
            end

            S_MRG_REP:
            begin
                // Replace the root with the pair sum and sift it down
                acc_next  = acc_sat;
                val_next  = pair_sum;
                hole_next = '0;
                ret_next  = RET_REP;
                rd0_addr  = IDX_W'(1);
                rd1_addr  = IDX_W'(2);
                if (count_reg > CNT_W'(1))
                begin
                    state_next = S_DN_CMP;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                    wr_data    = pair_sum;
                    state_next = S_MRG_RD;
                end
            end

            S_DN_CMP:
            begin
                // Move the smaller child up or settle the entry
                rd0_addr = nlc[IDX_W-1:0];
                rd1_addr = nrc[IDX_W-1:0];
                wr_en    = 1'b1;
                if (val_reg <= child_val)
                begin
                    state_next = done_state;
                end
                else
                begin
                    wr_data    = child_val;
                    hole_next  = child_idx;
                    state_next = next_has_child ? S_DN_CMP : S_WR_FIN;
                end
            end

            S_EMIT:
            begin
                // Load the result once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    count_next     = '0;
                    nsym_next      = '0;
                    acc_next       = '0;
                    ovf_next       = 1'b0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= RET_IN;
            last_reg      <= 1'b0;
            count_reg     <= '0;
            nsym_reg      <= '0;
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            last_reg      <= last_next;
            count_reg     <= count_next;
            nsym_reg      <= nsym_next;
            acc_reg       <= acc_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        hole_reg <= hole_next;
        val_reg  <= val_next;
        a_reg    <= a_next;
        if (out_load)
        begin
            total_cost_reg   <= acc_reg;
            symbol_count_reg <= sym_sat;
            overflow_reg     <= ovf_reg;
        end
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign total_cost   = total_cost_reg;
    assign symbol_count = symbol_count_reg;
    assign overflow     = overflow_reg;

endmodule

// File: rtl/hcc_checker.sv
// ----------------------------------------------------------------------------
// hcc_checker
// Port-level checks of the Huffman code cost unit, bound to the top level.
// ----------------------------------------------------------------------------
module hcc_checker
    import hcc_pkg::*;
#(
    parameter int MAX_SYMBOLS = 64
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                last,
    input logic                out_valid,
    input logic                out_ready,
    input logic [COST_W-1:0]   total_cost,
    input logic [COUNT_W-1:0]  symbol_count,
    input logic                overflow
);

    localparam logic [COUNT_W-1:0] FULL_COUNT =
        (MAX_SYMBOLS > 127) ? COUNT_MAX : COUNT_W'(MAX_SYMBOLS);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(total_cost)
            && $stable(symbol_count) && $stable(overflow))
        else $error("stalled result changed");

    // Every result covers at least one symbol
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> symbol_count != '0)
        else $error("result with zero symbols");

    // Go busy after the item marked last
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last |=> !in_ready)
        else $error("input ready right after last item");

    // A new result appears only out of the busy phase
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while input was ready");

    // An overflowed set reports a full heap
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> symbol_count == FULL_COUNT)
        else $error("overflow with heap not full");

endmodule

bind huffman_code_cost_unit hcc_checker #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
) u_hcc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .last         (last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .total_cost   (total_cost),
    .symbol_count (symbol_count),
    .overflow     (overflow)
);

// File: bench/huffman_code_cost_unit_tb.sv
// ----------------------------------------------------------------------------
// huffman_code_cost_unit_tb
// Self-checking bench for the Huffman code cost unit. Sets of symbol weights
// go in on a valid/ready channel. An in-bench model of the optimal merge
// cost predicts each result, which is compared field by field as it leaves.
// Directed sets come first, then random sets of mixed sizes that include
// full and overfull heaps. Both channels idle at random, and one long
// receiver hold-off fills the block so that it stalls its input.
// ----------------------------------------------------------------------------
module huffman_code_cost_unit_tb
    import hcc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SYMBOLS  = 64;
    localparam int WEIGHT_BITS  = 16;
    localparam int RANDOM_ITEMS = 1500;
    localparam int TAIL_ITEMS   = 150;    // no idling while this few items remain
    localparam int HOLD_CYCLES  = 400;    // long receiver hold-off
    localparam int HOLD_AT      = 12;     // results taken before the hold-off
    localparam int DRAIN_CYCLES = 1500;   // idle wait after the last result
    localparam int LIMIT_CYCLES = 600000;

    typedef struct {
        logic [WEIGHT_W-1:0] weight;
        logic                last;
    } symbol_item_t;

    typedef struct {
        logic [COST_W-1:0]  cost;
        logic [COUNT_W-1:0] count;
        logic               ovf;
    } cost_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [WEIGHT_W-1:0] weight = '0;
    logic                last = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [COST_W-1:0]   total_cost;
    logic [COUNT_W-1:0]  symbol_count;
    logic                overflow;

    symbol_item_t pending_symbols[$];
    cost_result_t expected_costs[$];
    longint       held_weights[$];     // weights of the set being collected
    logic         set_dropped = 1'b0;
    int           error_count = 0;
    int           results_taken = 0;
    int           send_gap = 0;
    int           take_stall = 0;
    int           hold_left = 0;
    logic         hold_done = 1'b0;

    huffman_code_cost_unit #(
        .MAX_SYMBOLS(MAX_SYMBOLS),
        .WEIGHT_BITS(WEIGHT_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .weight(weight),
        .last(last),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .total_cost(total_cost),
        .symbol_count(symbol_count),
        .overflow(overflow)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Merge the two lightest weights until one is left; return the summed merges, saturated at COST_MAX
    function automatic logic [COST_W-1:0] merge_cost(longint pool[$]);
        longint acc;
        longint pair_sum;
        int     lightest;
        acc = 0;
        while (pool.size() > 1)
        begin
            pair_sum = 0;
            repeat (2)
            begin
                lightest = 0;
                for (int i = 1; i < pool.size(); i++)
                    if (pool[i] < pool[lightest])
                        lightest = i;
                pair_sum += pool[lightest];
                pool.delete(lightest);
            end
            acc += pair_sum;
            if (acc > longint'(COST_MAX))
                acc = longint'(COST_MAX);
            pool.push_back(pair_sum);
        end
        return acc[COST_W-1:0];
    endfunction

    // Track one accepted symbol; close the set on an item marked last
    task automatic take_symbol(logic [WEIGHT_W-1:0] w, logic is_last);
        cost_result_t r;
        longint       wmask;
        wmask = (longint'(1) << WEIGHT_BITS) - 1;
        if (held_weights.size() < MAX_SYMBOLS)
            held_weights.push_back(longint'(w) & wmask);
        else
            set_dropped = 1'b1;
        if (is_last)
        begin
            r.cost  = merge_cost(held_weights);
            r.count = (held_weights.size() > int'(COUNT_MAX)) ? COUNT_MAX
                      : COUNT_W'(held_weights.size());
            r.ovf   = set_dropped;
            expected_costs.push_back(r);
            held_weights.delete();
            set_dropped = 1'b0;
        end
    endtask

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(0, 4))
            0:       return WEIGHT_W'($urandom_range(0, 15));
            1:       return $urandom_range(0, 1) ? '1 : '0;
            2:       return WEIGHT_W'($urandom_range(60000, 65535));
            default: return WEIGHT_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic queue_symbol(logic [WEIGHT_W-1:0] w, logic is_last);
        symbol_item_t it;
        it.weight = w;
        it.last   = is_last;
        pending_symbols.push_back(it);
    endtask

    task automatic queue_random_set(int set_size);
        for (int i = 0; i < set_size; i++)
            queue_symbol(pick_weight(), i == set_size - 1);
    endtask

    // Sender: predict on accept, then offer the next item or idle
    always @(posedge clk or negedge rst_n)
    begin
        symbol_item_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            weight   <= '0;
            last     <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                take_symbol(weight, last);
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_symbols.size() != 0)
                begin
                    nxt = pending_symbols.pop_front();
                    in_valid <= 1'b1;
                    weight   <= nxt.weight;
                    last     <= nxt.last;
                    if (pending_symbols.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0)
                        send_gap <= $urandom_range(1, 7);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Count down the one long receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && results_taken == HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Receiver: check each taken result against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        cost_result_t exp_r;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            take_stall <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_taken <= results_taken + 1;
                if (expected_costs.size() == 0)
                begin
                    $error("unexpected result: total_cost=%0d symbol_count=%0d overflow=%0b",
                           total_cost, symbol_count, overflow);
                    error_count++;
                end
                else
                begin
                    exp_r = expected_costs.pop_front();
                    if (total_cost !== exp_r.cost)
                    begin
                        $error("total_cost: expected %0d, actual %0d", exp_r.cost, total_cost);
                        error_count++;
                    end
                    if (symbol_count !== exp_r.count)
                    begin
                        $error("symbol_count: expected %0d, actual %0d",
                               exp_r.count, symbol_count);
                        error_count++;
                    end
                    if (overflow !== exp_r.ovf)
                    begin
                        $error("overflow: expected %0b, actual %0b", exp_r.ovf, overflow);
                        error_count++;
                    end
                end
            end
            if (hold_left != 0)
                out_ready <= 1'b0;
            else if (take_stall != 0)
            begin
                take_stall <= take_stall - 1;
                out_ready  <= 1'b0;
            end
            else if (pending_symbols.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0)
            begin
                take_stall <= $urandom_range(0, 6);
                out_ready  <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Stimulus and end of run
    initial
    begin
        int queued;
        int r;

        // single symbol at both extremes
        queue_symbol(16'h0000, 1'b1);
        queue_symbol(16'hFFFF, 1'b1);
        // two heaviest weights, two zero weights
        queue_symbol(16'hFFFF, 1'b0);
        queue_symbol(16'hFFFF, 1'b1);
        queue_symbol(16'h0000, 1'b0);
        queue_symbol(16'h0000, 1'b1);
        // ties
        queue_symbol(16'd1, 1'b0);
        queue_symbol(16'd1, 1'b0);
        queue_symbol(16'd2, 1'b0);
        queue_symbol(16'd2, 1'b1);
        // alternating and single-bit patterns
        queue_symbol(16'hAAAA, 1'b0);
        queue_symbol(16'h5555, 1'b0);
        queue_symbol(16'h0001, 1'b0);
        queue_symbol(16'h8000, 1'b1);
        // unsorted arrival order
        queue_symbol(16'd5, 1'b0);
        queue_symbol(16'd3, 1'b0);
        queue_symbol(16'd9, 1'b0);
        queue_symbol(16'd1, 1'b0);
        queue_symbol(16'd7, 1'b1);

        // full heap, then a set that overruns it
        queue_random_set(MAX_SYMBOLS);
        queue_random_set(MAX_SYMBOLS + 3);
        queued = 2 * MAX_SYMBOLS + 3;
        while (queued < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                r = $urandom_range(1, 8);
            else if (r < 92)
                r = $urandom_range(9, 40);
            else if (r < 97)
                r = $urandom_range(41, MAX_SYMBOLS);
            else
                r = $urandom_range(MAX_SYMBOLS + 1, MAX_SYMBOLS + 8);
            queue_random_set(r);
            queued += r;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // wait for every item to be taken, then for every result
        while (pending_symbols.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_costs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_costs.size() == 0)
            $display("huffman_code_cost_unit_tb: PASS");
        else
            $display("huffman_code_cost_unit_tb: FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(LIMIT_CYCLES * 12);
        $display("huffman_code_cost_unit_tb: FAIL");
        $finish;
    end

endmodule

// File: filelist.f
rtl/hcc_pkg.sv
rtl/huffman_code_cost_unit.sv
rtl/hcc_checker.sv
bench/huffman_code_cost_unit_tb.sv
